>>> hdl/jfn_pkg.sv
// Shared widths, register indexes and arithmetic for the five-point stencil.
package jfn_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int SUM_W       = SAMPLE_W + 2;
	localparam int COLS_W      = 11;
	localparam int ROWS_W      = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_COLS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROWS = 1'd1;

	localparam logic [COLS_W-1:0] COLS_RESET = 11'd64;
	localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd64;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// floor of the four-term sum over four: exact sum, arithmetic shift by two
	function automatic sample_t quarter_sum(sample_t a, sample_t b, sample_t c, sample_t d);
		logic signed [SUM_W-1:0] sum;
		sum = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d);
		return sum[SUM_W-1:2];
	endfunction

endpackage

>>> hdl/jfn_line_cell.sv
// One line-store cell: keeps one past row, hands the displaced sample to the next cell.
module jfn_line_cell #(
	parameter int DEPTH = 1026,
	parameter int AW    = 11,
	parameter int READS = 1
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [AW-1:0]                           wr_addr,
	input  jfn_pkg::sample_t                        wr_data,
	input  logic [READS-1:0][AW-1:0]                rd_addr,
	output logic [READS-1:0][jfn_pkg::SAMPLE_W-1:0] rd_data
);
	import jfn_pkg::*;

	sample_t line_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= wr_data;
		end
		for (int i = 0; i < READS; i++) begin
			rd_data[i] <= line_mem[rd_addr[i]];
		end
	end

endmodule

>>> hdl/jacobi_four_neighbor_stencil.sv
// Top level of the streaming five-point Jacobi stencil over one haloed tile.
//
//  channel   direction  payload (low bit up)              transaction when
//  s_*       in         tdata: sample[31:0]                s_tvalid & s_tready
//  m_*       out        tdata: avg_value[31:0]; tlast: eof m_tvalid & m_tready
//  cfg_*     in         index, data[12:0]                  cfg_we
//
// One sample per cycle while s_tready is high; the sample below a cell pushes its result.
// Both line cells read the coming column every cycle; the first also reads the one after.
// A two-entry output stage keeps s_tready high while one result waits.
// Reset clears counters, left sample, output valids and sets both sizes to 64.
// A configuration write restarts the frame with the next sample.
module jacobi_four_neighbor_stencil #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,   // sample[31:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,   // avg_value[31:0]
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [jfn_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [jfn_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import jfn_pkg::*;

	localparam int DEPTH = MAX_COLS + 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_ROWS + 2);

	logic [COLS_W-1:0] cfg_cols_q;
	logic [ROWS_W-1:0] cfg_rows_q;
	logic [AW-1:0]     cols_eff;
	logic [RW-1:0]     rows_eff;
	logic [AW-1:0]     col_q, col_d;
	logic [RW-1:0]     row_q, row_d;
	logic [AW:0]       ahead_sum;
	logic [AW-1:0]     ahead_addr;
	sample_t           left_q;
	sample_t           above, right, up, sample;
	logic [1:0][SAMPLE_W-1:0] line_one_rd;
	logic              accept, has_result, is_eof, row_end, push;
	sample_t           avg_new;

	logic              o_valid_q, o_last_q, k_valid_q, k_last_q;
	sample_t           o_data_q, k_data_q;

	always_comb begin
		if (cfg_cols_q == '0) begin
			cols_eff = AW'(1);
		end else if (32'(cfg_cols_q) > 32'(MAX_COLS)) begin
			cols_eff = AW'(MAX_COLS);
		end else begin
			cols_eff = AW'(cfg_cols_q);
		end
		if (cfg_rows_q == '0) begin
			rows_eff = RW'(1);
		end else if (32'(cfg_rows_q) > 32'(MAX_ROWS)) begin
			rows_eff = RW'(MAX_ROWS);
		end else begin
			rows_eff = RW'(cfg_rows_q);
		end
	end

	assign sample     = s_tdata;
	assign s_tready   = !k_valid_q;
	assign accept     = s_tvalid && s_tready;
	assign row_end    = col_q >= cols_eff + AW'(1);
	assign has_result = (row_q >= RW'(2)) && (col_q >= AW'(1)) && (col_q <= cols_eff);
	assign is_eof     = (row_q == rows_eff + RW'(1)) && (col_q == cols_eff);
	assign push       = accept && has_result;
	assign avg_new    = quarter_sum(up, sample, left_q, right);

	always_comb begin
		col_d = col_q;
		row_d = row_q;
		if (cfg_we) begin
			col_d = '0;
			row_d = '0;
		end else if (accept) begin
			if (row_end) begin
				col_d = '0;
				row_d = (row_q >= rows_eff + RW'(1)) ? '0 : row_q + RW'(1);
			end else begin
				col_d = col_q + AW'(1);
			end
		end
	end

	assign ahead_sum  = {1'b0, col_d} + (AW+1)'(1);
	assign ahead_addr = (ahead_sum >= (AW+1)'(DEPTH)) ? '0 : ahead_sum[AW-1:0];

	jfn_line_cell #(.DEPTH(DEPTH), .AW(AW), .READS(2)) u_cell_one (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col_q),
		.wr_data (sample),
		.rd_addr ({ahead_addr, col_d}),
		.rd_data (line_one_rd)
	);

	assign above = line_one_rd[0];
	assign right = line_one_rd[1];

	jfn_line_cell #(.DEPTH(DEPTH), .AW(AW), .READS(1)) u_cell_two (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col_q),
		.wr_data (above),
		.rd_addr (col_d),
		.rd_data (up)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cols_q <= COLS_RESET;
			cfg_rows_q <= ROWS_RESET;
			col_q      <= '0;
			row_q      <= '0;
			left_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COLS: cfg_cols_q <= COLS_W'(cfg_data);
					REG_ROWS: cfg_rows_q <= cfg_data;
					default: ;
				endcase
			end
			col_q <= col_d;
			row_q <= row_d;
			if (accept) begin
				left_q <= above;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			k_valid_q <= 1'b0;
		end else begin
			if (!o_valid_q || m_tready) begin
				if (k_valid_q) begin
					o_valid_q <= 1'b1;
					k_valid_q <= 1'b0;
				end else begin
					o_valid_q <= push;
				end
			end else if (push) begin
				k_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!o_valid_q || m_tready) begin
			if (k_valid_q) begin
				o_data_q <= k_data_q;
				o_last_q <= k_last_q;
			end else begin
				o_data_q <= avg_new;
				o_last_q <= is_eof;
			end
		end else if (push) begin
			k_data_q <= avg_new;
			k_last_q <= is_eof;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = o_data_q;
	assign m_tlast  = o_last_q;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		k_valid_q |-> o_valid_q)
		else $error("skid entry held without output entry");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= cols_eff + AW'(1))
		else $error("column counter beyond row end");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_we && row_end && (row_q >= rows_eff + RW'(1)))
		|=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap at frame end");

	a_eof_at_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(push && is_eof) |-> (col_q == cols_eff && !row_end))
		else $error("end of frame flagged off the last interior cell");

endmodule
